/* hw/rtl/tca_pkg.sv */
// ----------------------------------------------------------------------------
// tca_pkg
// Types and codes shared by the terminal cursor engine and its checker.
// ----------------------------------------------------------------------------
package tca_pkg;

  // Input command codes
  localparam logic [2:0] OP_WRITE   = 3'd0;
  localparam logic [2:0] OP_SETCUR  = 3'd1;
  localparam logic [2:0] OP_ALT_ON  = 3'd2;
  localparam logic [2:0] OP_ALT_OFF = 3'd3;
  localparam logic [2:0] OP_RESIZE  = 3'd4;

  // Result command codes for the cell store
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_SCROLL = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Padding cell contents
  localparam logic [20:0] SPACE_CODE = 21'h20;
  localparam logic [7:0]  PAD_FLAGS  = 8'h04;
  localparam logic [7:0]  PAD_WIDTH  = 8'd1;
  localparam logic [7:0]  WIDTH_ODD  = 8'hff;

  // Reset screen size
  localparam int RESET_COLS = 80;
  localparam int RESET_ROWS = 24;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [20:0] char_code;
    logic [7:0]  char_width;
    logic [8:0]  fg_colour;
    logic [8:0]  bg_colour;
    logic [7:0]  cell_flags;
    logic [7:0]  target_col;
    logic [7:0]  target_row;
    logic [8:0]  new_cols;
    logic [8:0]  new_rows;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  command;
    logic        buffer_sel;
    logic [7:0]  cell_col;
    logic [7:0]  cell_row;
    logic [20:0] out_code;
    logic [7:0]  out_width;
    logic [8:0]  out_fg;
    logic [8:0]  out_bg;
    logic [7:0]  out_flags;
    logic        last;
  } out_item_t;

endpackage

/* hw/rtl/terminal_cursor_autowrap.sv */
// ----------------------------------------------------------------------------
// terminal_cursor_autowrap
// Cursor engine of a text terminal with deferred wrap and alternate screen.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  tca_pkg::in_item_t (one command)
//   out_     output     out_valid/out_stall tca_pkg::out_item_t (store command)
//
// A command is processed from the input register; its zero to three results
// enter a four-slot queue that sends one result a cycle while out_stall is low,
// and a command's first result leaves from the queue head after passing the
// input register and the queue. The input stalls while a command waits and the
// queue would hold more than one result after this cycle's send. Reset
// (rst_n low, synchronous) empties both stages and sets an 80x24 screen.
// ----------------------------------------------------------------------------
module terminal_cursor_autowrap #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tca_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tca_pkg::out_item_t  out_item
);
  import tca_pkg::*;

  // Widths of screen sizes and cursor; they also hold the reset size
  localparam int CW  = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7;
  localparam int RW  = ($clog2(MAX_ROWS + 1) > 5) ? $clog2(MAX_ROWS + 1) : 5;
  localparam int CAW = ((CW > 9) ? CW : 9) + 1;
  localparam int RAW = ((RW > 9) ? RW : 9) + 1;

  localparam int QD  = 4;

  // Input register
  logic      s1_valid_r;
  in_item_t  s1_item_r;

  // Cursor state
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          wrap_r, wrap_nxt;
  logic          alt_r, alt_nxt;
  logic [CW-1:0] scol_r, scol_nxt;
  logic [RW-1:0] srow_r, srow_nxt;
  logic [CW-1:0] cols_r, cols_nxt;
  logic [RW-1:0] rows_r, rows_nxt;

  // Result queue, slot 0 is the head
  out_item_t     q_r   [QD];
  out_item_t     q_nxt [QD];
  logic [2:0]    cnt_r, cnt_nxt;

  out_item_t     res [4];
  logic [1:0]    n_res;

  logic          pop;
  logic [2:0]    base;
  logic          s1_go;
  logic          in_take;

  // Work values for one command
  logic [CW-1:0]  c_w;
  logic [RW-1:0]  r_w;
  logic [7:0]     w_eff;
  logic [CAW-1:0] sum_c;
  logic [CAW-1:0] padc;
  logic [CAW-1:0] tcol_x;
  logic [RAW-1:0] trow_x;
  logic [CAW-1:0] ncol_x;
  logic [RAW-1:0] nrow_x;
  logic [CW-1:0]  size_c;
  logic [RW-1:0]  size_r;
  logic [RAW-1:0] rowx_w;

  // Handshake
  assign out_valid = (cnt_r != 3'd0);
  assign out_item  = q_r[0];
  assign pop       = out_valid && !out_stall;
  assign base      = cnt_r - {2'b00, pop};
  assign s1_go     = s1_valid_r && (base <= 3'd1);
  assign in_stall  = s1_valid_r && !(base <= 3'd1);
  assign in_take   = in_valid && !in_stall;

  // Process the registered command
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    wrap_nxt = wrap_r;
    alt_nxt  = alt_r;
    scol_nxt = scol_r;
    srow_nxt = srow_r;
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    for (int i = 0; i < 4; i++) begin
      res[i] = '0;
      res[i].buffer_sel = alt_r;
    end
    n_res  = 2'd0;
    c_w    = col_r;
    r_w    = row_r;
    w_eff  = s1_item_r.char_width;
    sum_c  = '0;
    padc   = '0;
    tcol_x = CAW'(s1_item_r.target_col);
    trow_x = RAW'(s1_item_r.target_row);
    ncol_x = CAW'(s1_item_r.new_cols);
    nrow_x = RAW'(s1_item_r.new_rows);
    size_c = cols_r;
    size_r = rows_r;
    rowx_w = RAW'(row_r) + RAW'(1);

    if (w_eff == 8'd0 || w_eff == WIDTH_ODD) begin
      w_eff = 8'd1;
    end

    case (s1_item_r.opcode)
      OP_WRITE: begin
        // Resolve a pending wrap: next row, or scroll on the last row
        if (wrap_r) begin
          c_w = '0;
          if (rowx_w >= RAW'(rows_r)) begin
            res[0].command = CMD_SCROLL;
            n_res = 2'd1;
          end else begin
            r_w = rowx_w[RW-1:0];
          end
        end
        res[n_res].command    = CMD_WRITE;
        res[n_res].cell_col   = 8'(CAW'(c_w));
        res[n_res].cell_row   = 8'(RAW'(r_w));
        res[n_res].out_code   = s1_item_r.char_code;
        res[n_res].out_width  = s1_item_r.char_width;
        res[n_res].out_fg     = s1_item_r.fg_colour;
        res[n_res].out_bg     = s1_item_r.bg_colour;
        res[n_res].out_flags  = s1_item_r.cell_flags;
        n_res = n_res + 2'd1;
        // Padding cell for a double-width character
        padc = CAW'(c_w) + CAW'(1);
        if (w_eff == 8'd2 && padc < CAW'(cols_r)) begin
          res[n_res].command   = CMD_WRITE;
          res[n_res].cell_col  = padc[7:0];
          res[n_res].cell_row  = 8'(RAW'(r_w));
          res[n_res].out_code  = SPACE_CODE;
          res[n_res].out_width = PAD_WIDTH;
          res[n_res].out_fg    = s1_item_r.fg_colour;
          res[n_res].out_bg    = s1_item_r.bg_colour;
          res[n_res].out_flags = PAD_FLAGS;
          n_res = n_res + 2'd1;
        end
        // Advance, holding at the last column with wrap pending
        sum_c = CAW'(c_w) + CAW'(w_eff);
        if (sum_c >= CAW'(cols_r)) begin
          col_nxt  = cols_r - CW'(1);
          wrap_nxt = 1'b1;
        end else begin
          col_nxt  = sum_c[CW-1:0];
          wrap_nxt = 1'b0;
        end
        row_nxt = r_w;
      end
      OP_SETCUR: begin
        col_nxt  = (tcol_x >= CAW'(cols_r)) ? cols_r - CW'(1) : tcol_x[CW-1:0];
        row_nxt  = (trow_x >= RAW'(rows_r)) ? rows_r - RW'(1) : trow_x[RW-1:0];
        wrap_nxt = 1'b0;
      end
      OP_ALT_ON: begin
        if (!alt_r) begin
          scol_nxt = col_r;
          srow_nxt = row_r;
          col_nxt  = '0;
          row_nxt  = '0;
          wrap_nxt = 1'b0;
          alt_nxt  = 1'b1;
          res[0].command    = CMD_CLEAR;
          res[0].buffer_sel = 1'b1;
          n_res = 2'd1;
        end
      end
      OP_ALT_OFF: begin
        if (alt_r) begin
          col_nxt  = (CAW'(scol_r) >= CAW'(cols_r)) ? cols_r - CW'(1) : scol_r;
          row_nxt  = (RAW'(srow_r) >= RAW'(rows_r)) ? rows_r - RW'(1) : srow_r;
          wrap_nxt = 1'b0;
          alt_nxt  = 1'b0;
        end
      end
      OP_RESIZE: begin
        // Saturate the new size to 1..MAX
        if (ncol_x == '0) begin
          size_c = CW'(1);
        end else if (ncol_x > CAW'(MAX_COLS)) begin
          size_c = CW'(MAX_COLS);
        end else begin
          size_c = ncol_x[CW-1:0];
        end
        if (nrow_x == '0) begin
          size_r = RW'(1);
        end else if (nrow_x > RAW'(MAX_ROWS)) begin
          size_r = RW'(MAX_ROWS);
        end else begin
          size_r = nrow_x[RW-1:0];
        end
        cols_nxt = size_c;
        rows_nxt = size_r;
        if (col_r >= size_c) begin
          col_nxt = size_c - CW'(1);
        end
        if (row_r >= size_r) begin
          row_nxt = size_r - RW'(1);
        end
      end
      default: begin
      end
    endcase

    // Mark the final result of this command
    if (n_res != 2'd0) begin
      res[n_res - 2'd1].last = 1'b1;
    end
  end

  // Shift out the head, then append new results behind what remains
  always_comb begin
    for (int j = 0; j < QD; j++) begin
      q_nxt[j] = q_r[j];
      if (pop && j < QD - 1) begin
        q_nxt[j] = q_r[j + 1];
      end
      if (s1_go && 3'(j) >= base && 3'(j) < base + {1'b0, n_res}) begin
        q_nxt[j] = res[2'(3'(j) - base)];
      end
    end
    cnt_nxt = base + (s1_go ? {1'b0, n_res} : 3'd0);
  end

  // Queue payload
  always_ff @(posedge clk) begin
    for (int j = 0; j < QD; j++) begin
      q_r[j] <= q_nxt[j];
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
  end

  // Control and cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cnt_r      <= 3'd0;
      col_r      <= '0;
      row_r      <= '0;
      wrap_r     <= 1'b0;
      alt_r      <= 1'b0;
      scol_r     <= '0;
      srow_r     <= '0;
      cols_r     <= CW'(RESET_COLS);
      rows_r     <= RW'(RESET_ROWS);
    end else begin
      cnt_r <= cnt_nxt;
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        wrap_r <= wrap_nxt;
        alt_r  <= alt_nxt;
        scol_r <= scol_nxt;
        srow_r <= srow_nxt;
        cols_r <= cols_nxt;
        rows_r <= rows_nxt;
      end
    end
  end

endmodule

/* hw/rtl/tca_checker.sv */
// ----------------------------------------------------------------------------
// tca_checker
// Port-level checks on the result stream of the terminal cursor engine.
// ----------------------------------------------------------------------------
module tca_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input tca_pkg::out_item_t  out_item
);
  import tca_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Clear of the alternate buffer is a lone result aimed at that buffer
  a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.command == CMD_CLEAR |-> out_item.last && out_item.buffer_sel)
    else $error("clear result not last or not on alternate buffer");

  // Scroll never ends an item
  a_scroll_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.command == CMD_SCROLL |-> !out_item.last)
    else $error("scroll result marked last");

  // A cell write follows a scroll at once
  a_scroll_then_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_item.command == CMD_SCROLL
    |=> out_valid && out_item.command == CMD_WRITE)
    else $error("scroll not followed by cell write");

endmodule

bind terminal_cursor_autowrap tca_checker u_tca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
